/* rtl/lset_pkg.sv */
// shared types and constants of the lightning sensor event tracker
`default_nettype none

package lset_pkg;

    // interrupt flag bit positions
    localparam int IRQ_W         = 4;
    localparam int IRQ_LIGHTNING = 3;
    localparam int IRQ_DISTURBER = 2;
    localparam int IRQ_NOISE     = 0;

    localparam logic [5:0]  DIST_OUT      = 6'd63;
    localparam logic [5:0]  DIST_OVERHEAD = 6'd1;
    localparam logic [15:0] DIST_CNT_MAX  = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FLOOR_DEFAULT = 3'd0,
        REG_FLOOR_MAX     = 3'd1,
        REG_DECAY_QUIET   = 3'd2,
        REG_STORM_HOLD    = 3'd3,
        REG_WINDOW        = 3'd4
    } cfg_idx_t;

    // seconds from microseconds: drop 2^6, then divide by 15625 one 14-bit digit at a time
    localparam int          DIV_DIGIT_W = 14;
    localparam int          DIV_IN_W    = 42;
    localparam int          DIV_Q_W     = 29;
    localparam int          DIV_SHIFT   = 42;
    localparam logic [13:0] DIV_DIVISOR = 14'd15625;
    localparam logic [28:0] DIV_RECIP   = 29'd281474977;
    localparam int          DIV_LAT     = 6;

    // result fields travelling alongside the seconds divider
    typedef struct packed {
        logic        storm;
        logic [5:0]  range_km;
        logic        overhead;
        logic        beyond_range;
        logic [20:0] energy;
        logic [31:0] total;
        logic        seen;
        logic [2:0]  floor_lvl;
        logic        floor_chg;
        logic [15:0] dist_per_win;
        logic        clear_req;
    } side_t;

endpackage

`default_nettype wire

/* rtl/lset_sec_div.sv */
// pipelined divide of elapsed time, already divided by 64, by 15625, one digit per two stages
`default_nettype none

module lset_sec_div
    import lset_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [DIV_IN_W-1:0]  us_div64,
    output logic      [DIV_Q_W-1:0]   seconds
);

    localparam int NW = 2 * DIV_DIGIT_W;
    localparam int PW = NW + DIV_Q_W;

    // high digit
    logic [NW-1:0] n2_reg;
    logic [PW-1:0] p2_reg;
    logic [NW-1:0] lo1_reg;
    logic [DIV_DIGIT_W-1:0] r2_reg;
    logic          q2_reg;
    logic [NW-1:0] lo2_reg;
    // middle digit
    logic [NW-1:0] n1_reg;
    logic [PW-1:0] p1_reg;
    logic [DIV_DIGIT_W-1:0] d0_reg;
    logic          q2b_reg;
    logic [DIV_DIGIT_W-1:0] r1_reg;
    logic [DIV_DIGIT_W:0]   q21_reg;
    logic [DIV_DIGIT_W-1:0] d0b_reg;
    // low digit
    logic [PW-1:0] p0_reg;
    logic [DIV_DIGIT_W:0]   q21b_reg;
    logic [DIV_Q_W-1:0]     q_reg;

    logic [NW-1:0] n2, n1, n0;
    logic [DIV_DIGIT_W-1:0] q2, q1, q0;
    logic [NW-1:0] rr2, rr1;

    assign n2  = {{DIV_DIGIT_W{1'b0}}, us_div64[DIV_IN_W-1 -: DIV_DIGIT_W]};
    assign q2  = p2_reg[DIV_SHIFT +: DIV_DIGIT_W];
    assign rr2 = n2_reg - NW'({{DIV_DIGIT_W{1'b0}}, q2} * NW'(DIV_DIVISOR));
    assign n1  = {r2_reg, lo2_reg[NW-1 -: DIV_DIGIT_W]};
    assign q1  = p1_reg[DIV_SHIFT +: DIV_DIGIT_W];
    assign rr1 = n1_reg - NW'({{DIV_DIGIT_W{1'b0}}, q1} * NW'(DIV_DIVISOR));
    assign n0  = {r1_reg, d0b_reg};
    assign q0  = p0_reg[DIV_SHIFT +: DIV_DIGIT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: high digit times reciprocal
            n2_reg   <= n2;
            p2_reg   <= PW'({{DIV_Q_W{1'b0}}, n2}) * PW'(DIV_RECIP);
            lo1_reg  <= us_div64[NW-1:0];
            // stage 2: quotient and remainder of high digit
            q2_reg   <= q2[0];
            r2_reg   <= rr2[DIV_DIGIT_W-1:0];
            lo2_reg  <= lo1_reg;
            // stage 3: remainder and middle digit times reciprocal
            n1_reg   <= n1;
            p1_reg   <= PW'({{DIV_Q_W{1'b0}}, n1}) * PW'(DIV_RECIP);
            d0_reg   <= lo2_reg[DIV_DIGIT_W-1:0];
            q2b_reg  <= q2_reg;
            // stage 4
            r1_reg   <= rr1[DIV_DIGIT_W-1:0];
            q21_reg  <= {q2b_reg, q1};
            d0b_reg  <= d0_reg;
            // stage 5: low digit times reciprocal
            p0_reg   <= PW'({{DIV_Q_W{1'b0}}, n0}) * PW'(DIV_RECIP);
            q21b_reg <= q21_reg;
            // stage 6
            q_reg    <= {q21b_reg, q0};
        end
    end

    assign seconds = q_reg;

endmodule

`default_nettype wire

/* rtl/lightning_sensor_event_tracker.sv */
// top level of the lightning sensor event tracker
//
// usage
//   s_ channel: one transfer per sensor poll; s_tuser carries the interrupt flags,
//   s_tdata the timestamp, distance and energy readings
//   m_ channel: exactly one result transfer per poll, in poll order
//   cfg_we/cfg_addr/cfg_wdata: register writes, taken on any edge with cfg_we high; the user
//   must write only while no poll is in flight, a rule the block itself leaves unenforced
// timing
//   a poll is captured in an input register; the tracker state and side_reg[0]
//   are updated from it, and the elapsed-seconds division runs six more stages
//   behind them; one poll per cycle is taken sustained while the output is not
//   stalled, the state update loop closing through combinational logic only
// reset
//   aresetn low clears the pipeline valid bits and the tracker state, and loads the
//   register defaults; s_tready is high straight after reset
// stall
//   when m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops in the same cycle; nothing is lost or repeated
`default_nettype none

module lightning_sensor_event_tracker
    import lset_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // poll input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [79:0]  s_tdata,   // now_us[47:0], distance_raw[53:48], energy_raw[74:54]
    input  wire logic [3:0]   s_tuser,   // irq_flags[3:0]
    // result output
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [119:0] m_tdata,   // storm_active[0], last_range_km[6:1], is_overhead[7],
                                         // is_beyond_range[8], strike_energy[29:9],
                                         // strike_total[61:30], seconds_since_strike[93:62],
                                         // floor_level[96:94], floor_changed[97],
                                         // disturbers_per_window[113:98], clear_request[114]
    // register writes
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [39:0]  cfg_wdata
);

    // saturating elapsed time
    function automatic logic [47:0] elapsed(input logic [47:0] now, input logic [47:0] then);
        return (now >= then) ? (now - then) : 48'd0;
    endfunction

    logic en;

    // configuration registers
    logic [2:0]  floor_def_reg;
    logic [2:0]  floor_max_reg;
    logic [39:0] decay_quiet_reg;
    logic [39:0] storm_hold_reg;
    logic [39:0] window_reg;

    // input register
    logic        in_valid_reg;
    logic [3:0]  in_irq_reg;
    logic [47:0] in_now_reg;
    logic [5:0]  in_dist_reg;
    logic [20:0] in_energy_reg;

    // tracker state
    logic [2:0]  floor_reg,  floor_next;
    logic [31:0] count_reg,  count_next;
    logic [5:0]  dist_reg,   dist_next;
    logic [20:0] energy_reg, energy_next;
    logic [47:0] stime_reg,  stime_next;
    logic        seen_reg,   seen_next;
    logic [47:0] ntime_reg,  ntime_next;
    logic        storm_reg,  storm_next;
    logic [15:0] drun_reg,   drun_next;
    logic [15:0] dpub_reg,   dpub_next;
    logic [47:0] wstart_reg, wstart_next;

    side_t       side_next;
    logic [47:0] strike_age;

    // result pipeline alongside the divider
    side_t       side_reg  [DIV_LAT+1];
    logic        valid_reg [DIV_LAT+1];
    logic [DIV_IN_W-1:0] age_div64_reg;
    logic [DIV_Q_W-1:0]  seconds;
    logic [31:0]         secs_out;
    side_t               res;

    assign en       = !valid_reg[DIV_LAT] || m_tready;
    assign s_tready = en;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_def_reg   <= 3'd2;
            floor_max_reg   <= 3'd7;
            decay_quiet_reg <= 40'd600000000;
            storm_hold_reg  <= 40'd3600000000;
            window_reg      <= 40'd60000000;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_FLOOR_DEFAULT: floor_def_reg   <= cfg_wdata[2:0];
                REG_FLOOR_MAX:     floor_max_reg   <= cfg_wdata[2:0];
                REG_DECAY_QUIET:   decay_quiet_reg <= cfg_wdata;
                REG_STORM_HOLD:    storm_hold_reg  <= cfg_wdata;
                REG_WINDOW:        window_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_irq_reg    <= s_tuser;
            in_now_reg    <= s_tdata[47:0];
            in_dist_reg   <= s_tdata[53:48];
            in_energy_reg <= s_tdata[74:54];
        end
    end

    // per-poll update, in order: lightning, disturber, noise, window, decay, storm expiry
    always_comb begin
        logic [2:0]  floor_a;
        logic [47:0] ntime_a;
        logic        clr;

        count_next  = count_reg;
        dist_next   = dist_reg;
        energy_next = energy_reg;
        stime_next  = stime_reg;
        seen_next   = seen_reg;
        storm_next  = storm_reg;
        drun_next   = drun_reg;
        dpub_next   = dpub_reg;
        wstart_next = wstart_reg;
        clr         = 1'b0;

        if (in_irq_reg[IRQ_LIGHTNING]) begin
            dist_next   = in_dist_reg;
            energy_next = in_energy_reg;
            count_next  = count_reg + 32'd1;
            stime_next  = in_now_reg;
            seen_next   = 1'b1;
            storm_next  = 1'b1;
        end

        if (in_irq_reg[IRQ_DISTURBER] && drun_reg != DIST_CNT_MAX) begin
            drun_next = drun_reg + 16'd1;
        end

        floor_a = floor_reg;
        ntime_a = ntime_reg;
        if (in_irq_reg[IRQ_NOISE]) begin
            ntime_a = in_now_reg;
            if (floor_reg < floor_max_reg) begin
                floor_a = floor_reg + 3'd1;
            end
        end

        // window rollover publishes the running disturber count
        if (elapsed(in_now_reg, wstart_reg) >= {8'd0, window_reg}) begin
            dpub_next   = drun_next;
            drun_next   = 16'd0;
            wstart_next = in_now_reg;
        end

        // quiet spell steps a floor above its default back down toward it
        floor_next = floor_a;
        ntime_next = ntime_a;
        if (floor_a > floor_def_reg
                && elapsed(in_now_reg, ntime_a) >= {8'd0, decay_quiet_reg}) begin
            floor_next = floor_a - 3'd1;
            ntime_next = in_now_reg;
        end

        // storm hold expiry
        if (storm_next && elapsed(in_now_reg, stime_next) >= {8'd0, storm_hold_reg}) begin
            storm_next  = 1'b0;
            dist_next   = DIST_OUT;
            energy_next = 21'd0;
            clr         = 1'b1;
        end

        strike_age = elapsed(in_now_reg, stime_next);

        side_next.storm        = storm_next;
        side_next.range_km     = dist_next;
        side_next.overhead     = storm_next && (dist_next == DIST_OVERHEAD);
        side_next.beyond_range = (dist_next == DIST_OUT);
        side_next.energy       = energy_next;
        side_next.total        = count_next;
        side_next.seen         = seen_next;
        side_next.floor_lvl    = floor_next;
        side_next.floor_chg    = (floor_next != floor_reg);
        side_next.dist_per_win = dpub_next;
        side_next.clear_req    = clr;
    end

    // tracker state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg  <= 3'd2;
            count_reg  <= 32'd0;
            dist_reg   <= DIST_OUT;
            energy_reg <= 21'd0;
            stime_reg  <= 48'd0;
            seen_reg   <= 1'b0;
            ntime_reg  <= 48'd0;
            storm_reg  <= 1'b0;
            drun_reg   <= 16'd0;
            dpub_reg   <= 16'd0;
            wstart_reg <= 48'd0;
        end else if (en && in_valid_reg) begin
            floor_reg  <= floor_next;
            count_reg  <= count_next;
            dist_reg   <= dist_next;
            energy_reg <= energy_next;
            stime_reg  <= stime_next;
            seen_reg   <= seen_next;
            ntime_reg  <= ntime_next;
            storm_reg  <= storm_next;
            drun_reg   <= drun_next;
            dpub_reg   <= dpub_next;
            wstart_reg <= wstart_next;
        end
    end

    // result pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DIV_LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid_reg;
            for (int i = 1; i <= DIV_LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // result pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0]   <= side_next;
            age_div64_reg <= strike_age[47:6];
            for (int i = 1; i <= DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    lset_sec_div u_sec_div (
        .aclk     (aclk),
        .en       (en),
        .us_div64 (age_div64_reg),
        .seconds  (seconds)
    );

    assign res      = side_reg[DIV_LAT];
    assign secs_out = res.seen ? {3'd0, seconds} : 32'hFFFF_FFFF;

    assign m_tvalid = valid_reg[DIV_LAT];
    assign m_tdata  = {5'd0, res.clear_req, res.dist_per_win, res.floor_chg, res.floor_lvl,
                       secs_out, res.total, res.energy, res.beyond_range, res.overhead,
                       res.range_km, res.storm};

endmodule

`default_nettype wire
